// ----- rtl/lbsc_pkg.sv -----
// Package with shared types, constants and helper functions for the LED breathing color block.
package lbsc_pkg;

  localparam int TIME_BITS = 32;
  localparam int NOW_W = 32;
  localparam int COLOR_W = 8;
  localparam int PERIOD_W = 11;
  localparam int TRI_W = 10;
  localparam int LVL_NUM_W = 18;
  localparam int DIV_W = (TIME_BITS > LVL_NUM_W) ? TIME_BITS : LVL_NUM_W;
  localparam int CNT_W = $clog2(DIV_W + 1);
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 2;
  localparam int FRAME_GAP_MS = 20;

  localparam logic [CFG_IDX_W-1:0] REG_STAGE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AP_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SENSOR = 2'd2;

  localparam logic [1:0] STAGE_BOOT = 2'd0;
  localparam logic [1:0] STAGE_CONNECT = 2'd1;
  localparam logic [1:0] SENSOR_PENDING = 2'd0;
  localparam logic [1:0] SENSOR_ERROR = 2'd1;
  localparam logic [1:0] SENSOR_SATURATED = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GATE,
    ST_MOD,
    ST_TRI,
    ST_LSTART,
    ST_LDIV,
    ST_LEVEL,
    ST_MUL,
    ST_SCALE,
    ST_CMP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [COLOR_W-1:0]  base_r;
    logic [COLOR_W-1:0]  base_g;
    logic [COLOR_W-1:0]  base_b;
    logic [PERIOD_W-1:0] period;
    logic [COLOR_W-1:0]  lo;
    logic [COLOR_W-1:0]  hi;
    logic                steady;
  } mode_t;

  typedef struct packed {
    logic load_now;
    logic take_frame;
    logic start_mod;
    logic calc_tri;
    logic start_lvl;
    logic set_level;
    logic chan_clear;
    logic mul;
    logic scale;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic early;
    logic div_busy;
    logic last_chan;
    logic same;
    logic out_busy;
  } stat_t;

  function automatic mode_t mode_select(input logic [1:0] stage, input logic ap_mode,
                                        input logic [1:0] sensor);
    mode_t m;
    m.steady = 1'b0;
    if (stage == STAGE_BOOT) begin
      m.base_r = 8'd0;   m.base_g = 8'd0;   m.base_b = 8'd255;
      m.period = 11'd1800; m.lo = 8'd18; m.hi = 8'd255;
    end else if (stage == STAGE_CONNECT) begin
      m.base_r = 8'd0;   m.base_g = 8'd255; m.base_b = 8'd220;
      m.period = 11'd900;  m.lo = 8'd20; m.hi = 8'd255;
    end else if (sensor == SENSOR_ERROR) begin
      m.base_r = 8'd255; m.base_g = 8'd0;   m.base_b = 8'd0;
      m.period = 11'd1000; m.lo = 8'd16; m.hi = 8'd255;
    end else if (sensor == SENSOR_SATURATED) begin
      m.base_r = 8'd255; m.base_g = 8'd150; m.base_b = 8'd0;
      m.period = 11'd1100; m.lo = 8'd16; m.hi = 8'd255;
    end else if (sensor == SENSOR_PENDING) begin
      m.base_r = 8'd170; m.base_g = 8'd0;   m.base_b = 8'd255;
      m.period = 11'd1400; m.lo = 8'd14; m.hi = 8'd255;
    end else if (ap_mode) begin
      m.base_r = 8'd0;   m.base_g = 8'd85;  m.base_b = 8'd130;
      m.period = 11'd0;    m.lo = 8'd0;  m.hi = 8'd255;
      m.steady = 1'b1;
    end else begin
      m.base_r = 8'd170; m.base_g = 8'd0;   m.base_b = 8'd255;
      m.period = 11'd1500; m.lo = 8'd10; m.hi = 8'd220;
    end
    return m;
  endfunction

  // Exact floor(x / 255) for every product of two 8-bit values.
  function automatic logic [COLOR_W-1:0] div255(input logic [2*COLOR_W-1:0] x);
    logic [2*COLOR_W:0] t;
    t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return t[15:8];
  endfunction

endpackage

// ----- rtl/led_breathing_status_color_top.sv -----
// Top level of the LED breathing status color generator.
//
// Channel  Direction  Signals                            Payload
// s_*      in         s_tvalid s_tready s_tdata[31:0]    now_ms
// m_*      out        m_tvalid m_tready m_tdata[23:0]    red, green, blue
// cfg_*    in         cfg_valid cfg_ready cfg_index      cfg_data (0 stage, 1 ap_mode,
//                                                        2 sensor_status)
//
// A tick that arrives less than 20 ms after the last frame is dropped.
// A frame runs the serial divider for the modulo and then for the level; the divider
// retires one quotient bit per cycle. A frame whose color is unchanged emits no result.
// Reset clears the configuration, the frame time and the shown color to black.
// A result waits in the output register while the next tick is accepted; a new
// result stalls only while the previous one has not been taken.
module led_breathing_status_color_top import lbsc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [NOW_W-1:0]      s_tdata,   // [31:0] now_ms
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [3*COLOR_W-1:0]  m_tdata,   // [7:0] red, [15:8] green, [23:16] blue
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  lbsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lbsc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .now_ms    (s_tdata),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

// ----- rtl/lbsc_ctrl.sv -----
// Controller state machine that sequences the frame gate, divider runs and color scaling.
module lbsc_ctrl import lbsc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  output logic  s_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    s_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_now = 1'b1;
          state_next = ST_GATE;
        end
      end
      ST_GATE: begin
        if (stat.early) begin
          state_next = ST_IDLE;
        end else begin
          cmd.take_frame = 1'b1;
          state_next = ST_MOD;
        end
      end
      ST_MOD: begin
        if (!stat.div_busy) begin
          state_next = ST_TRI;
        end
      end
      ST_TRI: begin
        cmd.calc_tri = 1'b1;
        state_next = ST_LSTART;
      end
      ST_LSTART: begin
        cmd.start_lvl = 1'b1;
        state_next = ST_LDIV;
      end
      ST_LDIV: begin
        if (!stat.div_busy) begin
          state_next = ST_LEVEL;
        end
      end
      ST_LEVEL: begin
        cmd.set_level = 1'b1;
        cmd.chan_clear = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_next = stat.last_chan ? ST_CMP : ST_MUL;
      end
      ST_CMP: begin
        state_next = stat.same ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    cmd.start_mod = cmd.take_frame;
  end

`ifndef NO_ASSERTIONS
  a_gate_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> state == ST_GATE)
    else $error("accepted transaction did not reach the frame gate");
  a_emit_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !stat.out_busy)
    else $error("result loaded while the output register was still held");
  a_early_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_GATE && stat.early) |=> s_tready)
    else $error("early tick did not return to idle");
`endif

endmodule

// ----- rtl/lbsc_dp.sv -----
// Datapath with configuration registers, frame timer, serial divider, color scaling and output register.
module lbsc_dp import lbsc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  cmd_t                     cmd,
  output stat_t                    stat,
  input  logic [NOW_W-1:0]         now_ms,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [3*COLOR_W-1:0]     out_data
);

  logic [1:0]           stage;
  logic                 ap_mode;
  logic [1:0]           sensor_status;
  logic [TIME_BITS-1:0] now_q;
  logic [TIME_BITS-1:0] last_frame_time;
  logic [TIME_BITS-1:0] gap;
  mode_t                mode_now;
  mode_t                mode_q;
  logic [DIV_W-1:0]     dvd;
  logic [PERIOD_W-1:0]  divisor;
  logic [PERIOD_W-1:0]  rem;
  logic [COLOR_W-1:0]   quo;
  logic [CNT_W-1:0]     div_cnt;
  logic [PERIOD_W:0]    rem_shift;
  logic                 rem_ge;
  logic [PERIOD_W-1:0]  half;
  logic [PERIOD_W-1:0]  tri_wide;
  logic [LVL_NUM_W-1:0] prod;
  logic [TRI_W-1:0]     half_q;
  logic [COLOR_W-1:0]   lvl;
  logic [1:0]           chan;
  logic [COLOR_W-1:0]   base_sel;
  logic [2*COLOR_W-1:0] mul_q;
  logic [COLOR_W-1:0]   color [3];
  logic [COLOR_W-1:0]   shown [3];
  logic [COLOR_W:0]     lvl_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
      ap_mode <= 1'b0;
      sensor_status <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STAGE:   stage <= cfg_data[1:0];
        REG_AP_MODE: ap_mode <= cfg_data[0];
        REG_SENSOR:  sensor_status <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign mode_now = mode_select(stage, ap_mode, sensor_status);

  always_ff @(posedge clk) begin
    if (cmd.load_now) begin
      now_q <= TIME_BITS'(now_ms);
    end
    if (cmd.take_frame) begin
      mode_q <= mode_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_frame_time <= '0;
    end else if (cmd.take_frame) begin
      last_frame_time <= now_q;
    end
  end

  assign gap = now_q - last_frame_time;

  assign rem_shift = {rem, dvd[DIV_W-1]};
  assign rem_ge = rem_shift >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.start_mod) begin
      div_cnt <= CNT_W'(TIME_BITS);
    end else if (cmd.start_lvl) begin
      div_cnt <= CNT_W'(LVL_NUM_W);
    end else if (div_cnt != '0) begin
      div_cnt <= div_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_mod) begin
      dvd <= DIV_W'(now_q) << (DIV_W - TIME_BITS);
      divisor <= mode_now.period;
      rem <= '0;
    end else if (cmd.start_lvl) begin
      dvd <= DIV_W'(prod) << (DIV_W - LVL_NUM_W);
      divisor <= PERIOD_W'(half_q);
      rem <= '0;
    end else if (div_cnt != '0) begin
      dvd <= dvd << 1;
      rem <= rem_ge ? PERIOD_W'(rem_shift - {1'b0, divisor}) : rem_shift[PERIOD_W-1:0];
      quo <= {quo[COLOR_W-2:0], rem_ge};
    end
  end

  assign half = mode_q.period >> 1;
  assign tri_wide = (rem <= half) ? rem : (mode_q.period - rem);

  always_ff @(posedge clk) begin
    if (cmd.calc_tri) begin
      prod <= LVL_NUM_W'(mode_q.hi - mode_q.lo) * LVL_NUM_W'(tri_wide[TRI_W-1:0]);
      half_q <= half[TRI_W-1:0];
    end
  end

  assign lvl_sum = {1'b0, mode_q.lo} + {1'b0, quo};

  always_ff @(posedge clk) begin
    if (cmd.set_level) begin
      lvl <= lvl_sum[COLOR_W-1:0];
    end
  end

  always_comb begin
    case (chan)
      2'd0: base_sel = mode_q.base_r;
      2'd1: base_sel = mode_q.base_g;
      default: base_sel = mode_q.base_b;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chan <= '0;
    end else if (cmd.chan_clear) begin
      chan <= '0;
    end else if (cmd.scale) begin
      chan <= chan + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      mul_q <= base_sel * lvl;
    end
    if (cmd.scale) begin
      color[chan] <= mode_q.steady ? base_sel : div255(mul_q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shown[0] <= '0;
      shown[1] <= '0;
      shown[2] <= '0;
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      shown[0] <= color[0];
      shown[1] <= color[1];
      shown[2] <= color[2];
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= {color[2], color[1], color[0]};
    end
  end

  always_comb begin
    stat.early = gap < TIME_BITS'(FRAME_GAP_MS);
    stat.div_busy = div_cnt != '0;
    stat.last_chan = chan == 2'd2;
    stat.same = (color[0] == shown[0]) && (color[1] == shown[1]) && (color[2] == shown[2]);
    stat.out_busy = out_valid && !out_ready;
  end

`ifndef NO_ASSERTIONS
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.start_mod || cmd.start_lvl) |-> div_cnt == '0)
    else $error("divider restarted while still running");
  a_level_floor: assert property (@(posedge clk) disable iff (rst)
    (cmd.set_level && !mode_q.steady) |=> lvl >= mode_q.lo)
    else $error("breathing level fell below the mode minimum");
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid && (out_data == {shown[2], shown[1], shown[0]}))
    else $error("emitted color does not match the shown color");
`endif

endmodule
